FILE: design/bmpd_pkg.sv
// Shared types and constants for the BMP stream to RGBA decoder.
// No dependencies; imported by bmpd_decode and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bmpd_pkg;

   localparam int BMPD_MAX_WIDTH  = 4096;
   localparam int BMPD_MAX_HEIGHT = 4096;

   localparam logic [7:0]  BMP_CHAR_B           = 8'h42;
   localparam logic [7:0]  BMP_CHAR_M           = 8'h4D;
   localparam logic [31:0] BMP_MIN_INFO_SIZE    = 32'd40;
   localparam logic [32:0] BMP_FILE_HEADER_SIZE = 33'd14;
   localparam logic [15:0] BMP_PLANES           = 16'd1;
   localparam logic [15:0] BMP_DEPTH_24         = 16'd24;
   localparam logic [15:0] BMP_DEPTH_32         = 16'd32;
   localparam logic [7:0]  BMP_OPAQUE_ALPHA     = 8'hFF;

   typedef enum logic [3:0] {
      ST_PIXEL       = 4'd0,
      ST_SIGNATURE   = 4'd1,
      ST_SMALL_INFO  = 4'd2,
      ST_PLANES      = 4'd3,
      ST_DEPTH       = 4'd4,
      ST_COMPRESSED  = 4'd5,
      ST_TRUNCATED   = 4'd6,
      ST_DIMENSION   = 4'd7,
      ST_OFFSET      = 4'd8
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       final_byte;
   } step_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      logic [11:0] column;
      logic [11:0] row;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last_pixel;
   } result_type;

endpackage

`default_nettype wire

FILE: design/bmpd_decode.sv
// Parse state of the BMP decoder: header fields, skip counter and pixel walker.
// Depends on bmpd_pkg; one word is consumed per step, result is combinational.
`timescale 1ns / 1ps
`default_nettype none

module bmpd_decode
   import bmpd_pkg::*;
#(
   parameter int MAX_WIDTH  = BMPD_MAX_WIDTH,
   parameter int MAX_HEIGHT = BMPD_MAX_HEIGHT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire step_type   item,
   output result_type      result
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = $clog2(4 * MAX_WIDTH + 1);

   localparam logic [5:0] HDR_SIGNATURE   = 6'd1;
   localparam logic [5:0] HDR_OFFSET      = 6'd13;
   localparam logic [5:0] HDR_INFO_SIZE   = 6'd17;
   localparam logic [5:0] HDR_WIDTH       = 6'd21;
   localparam logic [5:0] HDR_HEIGHT      = 6'd25;
   localparam logic [5:0] HDR_PLANES      = 6'd27;
   localparam logic [5:0] HDR_DEPTH       = 6'd29;
   localparam logic [5:0] HDR_COMPRESSION = 6'd33;
   localparam logic [5:0] HDR_END         = 6'd37;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXELS,
      PH_DONE
   } phase_type;

   phase_type        phase_ff, phase_in, cur_phase;
   logic [31:0]      byte_offset_ff, byte_offset_in, cur_offset;
   logic [31:0]      field_acc_ff, field_acc_in, acc_new;
   logic [31:0]      pixel_offset_ff, pixel_offset_in;
   logic             width_bad_ff, width_bad_in;
   logic [WW-1:0]    image_width_ff, image_width_in;
   logic [HW-1:0]    image_height_ff, image_height_in;
   logic             bottom_up_ff, bottom_up_in;
   logic             four_byte_ff, four_byte_in;
   logic [RW-1:0]    row_data_ff, row_data_in;
   logic [RW-1:0]    stride_ff, stride_in;
   logic [WW-1:0]    column_count_ff, column_count_in;
   logic [HW-1:0]    row_count_ff, row_count_in;
   logic [RW-1:0]    byte_in_row_ff, byte_in_row_in;
   logic [1:0]       pixel_index_ff, pixel_index_in;
   logic [23:0]      pixel_bytes_ff, pixel_bytes_in;

   logic [15:0]      half;
   logic [31:0]      height_abs;
   logic [RW-1:0]    width_ext, row_data_calc;
   logic [RW:0]      pad_sum;
   logic [RW:0]      byte_in_row_next;
   logic [WW:0]      column_next;
   logic [HW:0]      row_next;
   logic [HW-1:0]    dest_row;
   logic [WW+11:0]   column_wide;
   logic [HW+11:0]   row_wide;
   logic             err_hit, pixel_hit, pixel_last, in_data, done_px;
   status_type       err_code;

   always_comb begin
      cur_phase      = item.first_byte ? PH_HEADER : phase_ff;
      cur_offset     = item.first_byte ? '0 : byte_offset_ff;
      acc_new        = {item.data_byte, field_acc_ff[31:8]};
      half           = acc_new[31:16];
      height_abs     = acc_new[31] ? (~acc_new + 32'd1) : acc_new;
      width_ext      = RW'(image_width_ff);
      row_data_calc  = four_byte_ff ? (width_ext << 2) : (width_ext + (width_ext << 1));
      pad_sum        = {1'b0, row_data_calc} + (RW + 1)'(3);

      in_data          = byte_in_row_ff < row_data_ff;
      done_px          = four_byte_ff ? (pixel_index_ff == 2'd3) : (pixel_index_ff == 2'd2);
      column_next      = {1'b0, column_count_ff} + (WW + 1)'(1);
      row_next         = {1'b0, row_count_ff} + (HW + 1)'(1);
      pixel_last       = (column_next == {1'b0, image_width_ff})
                         && (row_next == {1'b0, image_height_ff});
      byte_in_row_next = {1'b0, byte_in_row_ff} + (RW + 1)'(1);
      dest_row         = bottom_up_ff ? (image_height_ff - HW'(1) - row_count_ff)
                                      : row_count_ff;
      column_wide      = (WW + 12)'(column_count_ff);
      row_wide         = (HW + 12)'(dest_row);

      phase_in        = cur_phase;
      byte_offset_in  = byte_offset_ff;
      field_acc_in    = field_acc_ff;
      pixel_offset_in = pixel_offset_ff;
      width_bad_in    = width_bad_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      bottom_up_in    = bottom_up_ff;
      four_byte_in    = four_byte_ff;
      row_data_in     = row_data_ff;
      stride_in       = stride_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      byte_in_row_in  = byte_in_row_ff;
      pixel_index_in  = pixel_index_ff;
      pixel_bytes_in  = pixel_bytes_ff;
      err_hit         = 1'b0;
      err_code        = ST_PIXEL;
      pixel_hit       = 1'b0;

      // restart the walker for a new file
      if (item.first_byte) begin
         column_count_in = '0;
         row_count_in    = '0;
         byte_in_row_in  = '0;
         pixel_index_in  = '0;
         pixel_bytes_in  = '0;
      end

      unique case (cur_phase)
         PH_HEADER: begin
            field_acc_in = acc_new;
            unique case (cur_offset[5:0])
               HDR_SIGNATURE: begin
                  if (half != {BMP_CHAR_M, BMP_CHAR_B}) begin
                     err_hit  = 1'b1;
                     err_code = ST_SIGNATURE;
                  end
               end
               HDR_OFFSET: begin
                  pixel_offset_in = acc_new;
               end
               HDR_INFO_SIZE: begin
                  if (acc_new < BMP_MIN_INFO_SIZE) begin
                     err_hit  = 1'b1;
                     err_code = ST_SMALL_INFO;
                  end else if ({1'b0, pixel_offset_ff} <
                               BMP_FILE_HEADER_SIZE + {1'b0, acc_new}) begin
                     err_hit  = 1'b1;
                     err_code = ST_OFFSET;
                  end
               end
               HDR_WIDTH: begin
                  width_bad_in   = (acc_new == '0) || acc_new[31]
                                   || (acc_new > 32'(MAX_WIDTH));
                  image_width_in = acc_new[WW-1:0];
               end
               HDR_HEIGHT: begin
                  image_height_in = height_abs[HW-1:0];
                  bottom_up_in    = !acc_new[31];
                  if (width_bad_ff || (height_abs == '0)
                      || (height_abs > 32'(MAX_HEIGHT))) begin
                     err_hit  = 1'b1;
                     err_code = ST_DIMENSION;
                  end
               end
               HDR_PLANES: begin
                  if (half != BMP_PLANES) begin
                     err_hit  = 1'b1;
                     err_code = ST_PLANES;
                  end
               end
               HDR_DEPTH: begin
                  if (half == BMP_DEPTH_24) begin
                     four_byte_in = 1'b0;
                  end else if (half == BMP_DEPTH_32) begin
                     four_byte_in = 1'b1;
                  end else begin
                     err_hit  = 1'b1;
                     err_code = ST_DEPTH;
                  end
               end
               HDR_COMPRESSION: begin
                  if (acc_new != '0) begin
                     err_hit  = 1'b1;
                     err_code = ST_COMPRESSED;
                  end
               end
               HDR_END: begin
                  phase_in    = PH_SKIP;
                  row_data_in = row_data_calc;
                  stride_in   = {pad_sum[RW-1:2], 2'b00};
               end
               default: begin
               end
            endcase
         end
         PH_SKIP: begin
            if ({1'b0, cur_offset} + 33'd1 >= {1'b0, pixel_offset_ff}) begin
               phase_in = PH_PIXELS;
            end
         end
         PH_PIXELS: begin
            if (in_data) begin
               if (done_px) begin
                  pixel_hit       = 1'b1;
                  pixel_bytes_in  = '0;
                  pixel_index_in  = '0;
                  column_count_in = column_next[WW-1:0];
                  if (pixel_last) begin
                     phase_in = PH_DONE;
                  end
               end else begin
                  unique case (pixel_index_ff)
                     2'd0:    pixel_bytes_in[7:0]   = item.data_byte;
                     2'd1:    pixel_bytes_in[15:8]  = item.data_byte;
                     default: pixel_bytes_in[23:16] = item.data_byte;
                  endcase
                  pixel_index_in = pixel_index_ff + 2'd1;
               end
            end
            if (byte_in_row_next >= {1'b0, stride_ff}) begin
               byte_in_row_in  = '0;
               column_count_in = '0;
               pixel_index_in  = '0;
               pixel_bytes_in  = '0;
               row_count_in    = row_next[HW-1:0];
            end else begin
               byte_in_row_in = byte_in_row_next[RW-1:0];
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (cur_phase != PH_DONE) begin
         byte_offset_in = cur_offset + 32'd1;
      end

      result = '0;
      if (err_hit) begin
         phase_in      = PH_DONE;
         result.valid  = 1'b1;
         result.status = err_code;
      end else if ((cur_phase != PH_DONE) && item.final_byte && (phase_in != PH_DONE)) begin
         phase_in      = PH_DONE;
         result.valid  = 1'b1;
         result.status = ST_TRUNCATED;
      end else if (pixel_hit) begin
         result.valid      = 1'b1;
         result.status     = ST_PIXEL;
         result.column     = column_wide[11:0];
         result.row        = row_wide[11:0];
         result.green      = pixel_bytes_ff[15:8];
         result.blue       = pixel_bytes_ff[7:0];
         result.last_pixel = pixel_last;
         if (four_byte_ff) begin
            result.red   = pixel_bytes_ff[23:16];
            result.alpha = item.data_byte;
         end else begin
            result.red   = item.data_byte;
            result.alpha = BMP_OPAQUE_ALPHA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         byte_offset_ff  <= '0;
         field_acc_ff    <= '0;
         pixel_offset_ff <= '0;
         width_bad_ff    <= 1'b0;
         image_width_ff  <= '0;
         image_height_ff <= '0;
         bottom_up_ff    <= 1'b0;
         four_byte_ff    <= 1'b0;
         row_data_ff     <= '0;
         stride_ff       <= '0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         byte_in_row_ff  <= '0;
         pixel_index_ff  <= '0;
         pixel_bytes_ff  <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         byte_offset_ff  <= byte_offset_in;
         field_acc_ff    <= field_acc_in;
         pixel_offset_ff <= pixel_offset_in;
         width_bad_ff    <= width_bad_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         bottom_up_ff    <= bottom_up_in;
         four_byte_ff    <= four_byte_in;
         row_data_ff     <= row_data_in;
         stride_ff       <= stride_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         byte_in_row_ff  <= byte_in_row_in;
         pixel_index_ff  <= pixel_index_in;
         pixel_bytes_ff  <= pixel_bytes_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/bmp_stream_to_rgba_decoder_top.sv
// Top level of the BMP stream to RGBA decoder: input register, parser, result register.
// Depends on bmpd_pkg and bmpd_decode.
//
// Feed the file one byte per word with first_byte set on byte 0 and final_byte on the
// last byte. The block takes one word every cycle while req_stall is low and gives
// at most one word per input word: an RGBA pixel with its column and destination row,
// or one status word for a header error or truncation, after which bytes are dropped
// until the next first_byte. A taken byte sits in the input register, then the
// combinational parse step writes its result into the result register; that parse
// step sets the rate of one byte per cycle while the result side does not stall.
// Stalls on the result side hold the pipe without losing words.
`timescale 1ns / 1ps
`default_nettype none

module bmp_stream_to_rgba_decoder_top
   import bmpd_pkg::*;
#(
   parameter int MAX_WIDTH  = BMPD_MAX_WIDTH,
   parameter int MAX_HEIGHT = BMPD_MAX_HEIGHT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_status,
   output logic [11:0]      rsp_column,
   output logic [11:0]      rsp_row,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha,
   output logic             rsp_last_pixel
);

   logic       req_valid_ff, req_valid_in;
   step_type   req_word_ff, req_word_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_word_ff, rsp_word_in;
   result_type result;
   logic       out_free, step, accept;

   bmpd_decode #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_decode (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_word_ff),
      .result (result)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      step      = req_valid_ff && out_free;
      req_stall = req_valid_ff && !out_free;
      accept    = req_valid && !req_stall;

      req_valid_in = req_valid_ff;
      req_word_in  = req_word_ff;
      if (accept) begin
         req_valid_in = 1'b1;
         req_word_in  = '{data_byte: req_data_byte, first_byte: req_first_byte,
                          final_byte: req_final_byte};
      end else if (step) begin
         req_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_free) begin
         rsp_valid_in = step && result.valid;
         if (step && result.valid) begin
            rsp_word_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_word_ff <= req_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_word_ff.status;
   assign rsp_column     = rsp_word_ff.column;
   assign rsp_row        = rsp_word_ff.row;
   assign rsp_red        = rsp_word_ff.red;
   assign rsp_green      = rsp_word_ff.green;
   assign rsp_blue       = rsp_word_ff.blue;
   assign rsp_alpha      = rsp_word_ff.alpha;
   assign rsp_last_pixel = rsp_word_ff.last_pixel;

endmodule

`default_nettype wire

FILE: test/tb_bmp_stream_to_rgba_decoder_top.sv
// Testbench for bmp_stream_to_rgba_decoder_top: streams BMP files byte by byte and checks
// every RGBA pixel or status word against an in-bench decoder model.
// Depends on bmpd_pkg and the top level of the decoder.
`timescale 1ns / 1ps

module tb_bmp_stream_to_rgba_decoder_top;
   import bmpd_pkg::*;

   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_BYTES   = 200;

   localparam logic [15:0] BM_SIGNATURE = {BMP_CHAR_M, BMP_CHAR_B};

   localparam int POS_SIGNATURE    = 1;
   localparam int POS_PIXEL_OFFSET = 13;
   localparam int POS_INFO_SIZE    = 17;
   localparam int POS_WIDTH        = 21;
   localparam int POS_HEIGHT       = 25;
   localparam int POS_PLANES       = 27;
   localparam int POS_DEPTH        = 29;
   localparam int POS_COMPRESSION  = 33;
   localparam int POS_HEADER_END   = 37;

   typedef enum logic [1:0] {
      PARSE_HEADER,
      PARSE_SKIP,
      PARSE_PIXELS,
      PARSE_DONE
   } parse_phase_t;

   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES
   } fill_mode_t;

   typedef struct packed {
      status_type  status;
      logic [11:0] column;
      logic [11:0] row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        last_pixel;
   } pixel_word_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_first_byte = 1'b0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [11:0] rsp_column;
   logic [11:0] rsp_row;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic        rsp_last_pixel;

   bmp_stream_to_rgba_decoder_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_column     (rsp_column),
      .rsp_row        (rsp_row),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_last_pixel (rsp_last_pixel)
   );

   always #4 clock = ~clock;

   // decoder model state
   parse_phase_t phase;
   logic [31:0]  pos;
   logic [31:0]  pix_offset;
   logic [31:0]  info_size;
   logic [31:0]  width;
   logic [31:0]  height_abs;
   logic         bottom_up;
   logic         wide_pixels;
   logic [31:0]  col_cnt;
   logic [31:0]  row_cnt;
   logic [31:0]  row_byte;
   logic [1:0]   pix_idx;
   logic [23:0]  assembled;
   logic [31:0]  field_word;

   pixel_word_t  pending_words[$];
   logic [7:0]   file_image[$];
   int           image_end;
   fill_mode_t   pixel_fill = FILL_RANDOM;

   int  mismatch_count = 0;
   int  accepted_bytes = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_request = 1'b0;
   bit  gaps_enabled = 1'b1;
   bit  stalls_enabled = 1'b1;

   task automatic clear_decoder_state();
      phase       = PARSE_HEADER;
      pos         = '0;
      pix_offset  = '0;
      info_size   = '0;
      width       = '0;
      height_abs  = '0;
      bottom_up   = 1'b0;
      wide_pixels = 1'b0;
      col_cnt     = '0;
      row_cnt     = '0;
      row_byte    = '0;
      pix_idx     = '0;
      assembled   = '0;
      field_word  = '0;
   endtask

   function automatic status_type header_field_check(input logic [31:0] k);
      logic [15:0] half;
      half = field_word[31:16];
      case (k)
         POS_SIGNATURE: begin
            if (half != BM_SIGNATURE) return ST_SIGNATURE;
         end
         POS_PIXEL_OFFSET: pix_offset = field_word;
         POS_INFO_SIZE: begin
            info_size = field_word;
            if (info_size < BMP_MIN_INFO_SIZE) return ST_SMALL_INFO;
            if ({1'b0, pix_offset} < BMP_FILE_HEADER_SIZE + {1'b0, info_size})
               return ST_OFFSET;
         end
         POS_WIDTH: width = field_word;
         POS_HEIGHT: begin
            if (width == 0 || width[31] || width > BMPD_MAX_WIDTH) return ST_DIMENSION;
            if (field_word[31]) begin
               height_abs = ~field_word + 32'd1;
               bottom_up  = 1'b0;
            end else begin
               height_abs = field_word;
               bottom_up  = 1'b1;
            end
            if (height_abs == 0 || height_abs > BMPD_MAX_HEIGHT) return ST_DIMENSION;
         end
         POS_PLANES: begin
            if (half != BMP_PLANES) return ST_PLANES;
         end
         POS_DEPTH: begin
            if (half == BMP_DEPTH_24) wide_pixels = 1'b0;
            else if (half == BMP_DEPTH_32) wide_pixels = 1'b1;
            else return ST_DEPTH;
         end
         POS_COMPRESSION: begin
            if (field_word != 0) return ST_COMPRESSED;
         end
         POS_HEADER_END: phase = PARSE_SKIP;
         default: ;
      endcase
      return ST_PIXEL;
   endfunction

   task automatic predict_byte(input logic [7:0] d, input logic f, input logic l);
      status_type  err;
      bit          was_done;
      bit          emit;
      logic [31:0] bpp;
      logic [31:0] row_data;
      logic [31:0] stride;
      logic [31:0] drow;
      pixel_word_t word;
      err  = ST_PIXEL;
      emit = 1'b0;
      word = '0;
      if (f) clear_decoder_state();
      was_done = (phase == PARSE_DONE);
      case (phase)
         PARSE_HEADER: begin
            field_word = {d, field_word[31:8]};
            err = header_field_check(pos);
         end
         PARSE_SKIP: begin
            if ({1'b0, pos} + 33'd1 >= {1'b0, pix_offset}) phase = PARSE_PIXELS;
         end
         PARSE_PIXELS: begin
            bpp      = wide_pixels ? 32'd4 : 32'd3;
            row_data = width * bpp;
            stride   = (row_data + 32'd3) & ~32'd3;
            if (row_byte < row_data) begin
               if (pix_idx == (wide_pixels ? 2'd3 : 2'd2)) begin
                  if (wide_pixels) begin
                     word.red   = assembled[23:16];
                     word.green = assembled[15:8];
                     word.blue  = assembled[7:0];
                     word.alpha = d;
                  end else begin
                     word.red   = d;
                     word.green = assembled[15:8];
                     word.blue  = assembled[7:0];
                     word.alpha = BMP_OPAQUE_ALPHA;
                  end
                  word.last_pixel = (col_cnt + 1 == width) && (row_cnt + 1 == height_abs);
                  drow = bottom_up ? height_abs - 32'd1 - row_cnt : row_cnt;
                  word.status = ST_PIXEL;
                  word.column = col_cnt[11:0];
                  word.row    = drow[11:0];
                  emit      = 1'b1;
                  assembled = '0;
                  pix_idx   = '0;
                  col_cnt   = col_cnt + 1;
                  if (word.last_pixel) phase = PARSE_DONE;
               end else begin
                  assembled[pix_idx * 8 +: 8] = d;
                  pix_idx = pix_idx + 2'd1;
               end
            end
            row_byte = row_byte + 1;
            if (row_byte >= stride) begin
               row_byte  = '0;
               col_cnt   = '0;
               pix_idx   = '0;
               assembled = '0;
               row_cnt   = row_cnt + 1;
            end
         end
         default: ;
      endcase
      if (!was_done) pos = pos + 1;
      if (err != ST_PIXEL) begin
         word = '0;
         word.status = err;
         phase = PARSE_DONE;
         pending_words.push_back(word);
      end else if (!was_done && l && phase != PARSE_DONE) begin
         word = '0;
         word.status = ST_TRUNCATED;
         phase = PARSE_DONE;
         pending_words.push_back(word);
      end else if (emit) begin
         pending_words.push_back(word);
      end
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pixel_value();
      case (pixel_fill)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom);
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] d, input logic f, input logic l);
      int gap;
      gap = gaps_enabled ? pick_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= d;
      req_first_byte <= f;
      req_final_byte <= l;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      accepted_bytes++;
      predict_byte(d, f, l);
   endtask

   task automatic put_le(input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) file_image.push_back(v[8 * i +: 8]);
   endtask

   task automatic build_bmp(input logic [15:0] sig, input logic [31:0] offset,
                            input logic [31:0] info, input logic [31:0] w,
                            input logic [31:0] h, input logic [15:0] planes,
                            input logic [15:0] depth, input logic [31:0] comp,
                            input int data_len);
      int fill;
      file_image.delete();
      put_le({16'd0, sig}, 2);
      put_le($urandom, 4);
      put_le($urandom, 4);
      put_le(offset, 4);
      put_le(info, 4);
      put_le(w, 4);
      put_le(h, 4);
      put_le({16'd0, planes}, 2);
      put_le({16'd0, depth}, 2);
      put_le(comp, 4);
      put_le($urandom, 4);
      fill = (offset > 38 && offset < 300) ? int'(offset) - 38 : 0;
      repeat (fill) file_image.push_back(8'($urandom));
      repeat (data_len) file_image.push_back(pixel_value());
   endtask

   task automatic make_image(input int w, input int h, input bit wide,
                             input int extra_offset, input int extra_info);
      int stride;
      int rows;
      int info;
      int offset;
      stride = ((w * (wide ? 4 : 3)) + 3) & ~3;
      rows   = (h < 0) ? -h : h;
      info   = 40 + extra_info;
      offset = 14 + info + extra_offset;
      build_bmp(BM_SIGNATURE, offset, info, w, h, BMP_PLANES,
                wide ? BMP_DEPTH_32 : BMP_DEPTH_24, 32'd0, rows * stride);
      image_end = offset + (rows - 1) * stride + w * (wide ? 4 : 3);
   endtask

   task automatic send_file(input int keep, input bit mark_first, input bit mark_final);
      int n;
      n = (keep > 0 && keep < file_image.size()) ? keep : file_image.size();
      for (int i = 0; i < n; i++)
         send_byte(file_image[i], mark_first && i == 0, mark_final && i == n - 1);
   endtask

   task automatic header_case(input logic [31:0] offset, input logic [31:0] info,
                              input logic [31:0] w, input logic [31:0] h,
                              input logic [15:0] planes, input logic [15:0] depth,
                              input logic [31:0] comp, input int keep);
      build_bmp(BM_SIGNATURE, offset, info, w, h, planes, depth, comp, 0);
      send_file(keep, 1'b1, 1'b1);
   endtask

   task automatic check_rsp_word();
      pixel_word_t want;
      bit          bad;
      bad = 1'b0;
      if (pending_words.size() == 0) begin
         $error("result word with nothing pending: status %0d column %0d row %0d",
                rsp_status, rsp_column, rsp_row);
         mismatch_count++;
      end else begin
         want = pending_words.pop_front();
         if (rsp_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_status);
            bad = 1'b1;
         end
         if (rsp_column !== want.column) begin
            $error("column: expected %0d, got %0d", want.column, rsp_column);
            bad = 1'b1;
         end
         if (rsp_row !== want.row) begin
            $error("row: expected %0d, got %0d", want.row, rsp_row);
            bad = 1'b1;
         end
         if (rsp_red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, rsp_red);
            bad = 1'b1;
         end
         if (rsp_green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, rsp_green);
            bad = 1'b1;
         end
         if (rsp_blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, rsp_blue);
            bad = 1'b1;
         end
         if (rsp_alpha !== want.alpha) begin
            $error("alpha: expected %0d, got %0d", want.alpha, rsp_alpha);
            bad = 1'b1;
         end
         if (rsp_last_pixel !== want.last_pixel) begin
            $error("last_pixel: expected %0d, got %0d", want.last_pixel, rsp_last_pixel);
            bad = 1'b1;
         end
         if (bad) mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) check_rsp_word();
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = stalls_enabled ? pick_length() : 0;
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_signature();
      // first file after reset carries no start marker
      build_bmp(16'h4E42, 54, 40, 2, 2, BMP_PLANES, BMP_DEPTH_24, 0, 0);
      send_file(5, 1'b0, 1'b1);
      build_bmp(16'h424D, 54, 40, 2, 2, BMP_PLANES, BMP_DEPTH_24, 0, 0);
      send_file(4, 1'b1, 1'b1);
      build_bmp(BM_SIGNATURE, 54, 40, 2, 2, BMP_PLANES, BMP_DEPTH_24, 0, 0);
      send_file(2, 1'b1, 1'b1);
   endtask

   task automatic test_header_checks();
      header_case(54, 39, 2, 2, BMP_PLANES, BMP_DEPTH_24, 0, 20);
      header_case(10, 39, 2, 2, BMP_PLANES, BMP_DEPTH_24, 0, 20);
      header_case(53, 40, 2, 2, BMP_PLANES, BMP_DEPTH_24, 0, 20);
      header_case(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 2, BMP_PLANES, BMP_DEPTH_24, 0, 20);
      header_case(54, 40, 0, 2, BMP_PLANES, BMP_DEPTH_24, 0, 28);
      header_case(54, 40, 4097, 2, BMP_PLANES, BMP_DEPTH_24, 0, 28);
      header_case(54, 40, 32'h8000_0000, 2, BMP_PLANES, BMP_DEPTH_24, 0, 28);
      header_case(54, 40, 2, 0, BMP_PLANES, BMP_DEPTH_24, 0, 28);
      header_case(54, 40, 2, 4097, BMP_PLANES, BMP_DEPTH_24, 0, 28);
      header_case(54, 40, 2, -4097, BMP_PLANES, BMP_DEPTH_24, 0, 28);
      header_case(54, 40, 2, 32'h8000_0000, BMP_PLANES, BMP_DEPTH_24, 0, 28);
      header_case(54, 40, 2, 2, 16'd0, BMP_DEPTH_24, 0, 30);
      header_case(54, 40, 2, 2, 16'hFFFF, BMP_DEPTH_24, 0, 30);
      header_case(54, 40, 2, 2, BMP_PLANES, 16'd16, 0, 32);
      header_case(54, 40, 2, 2, BMP_PLANES, 16'hFFFF, 0, 32);
      header_case(54, 40, 2, 2, BMP_PLANES, BMP_DEPTH_24, 1, 36);
      header_case(54, 40, 2, 2, BMP_PLANES, BMP_DEPTH_32, 32'h8000_0000, 36);
   endtask

   task automatic test_pixel_formats();
      make_image(3, 2, 1'b0, 0, 0);
      send_file(0, 1'b1, 1'b1);
      make_image(2, -2, 1'b1, 5, 0);
      send_file(image_end, 1'b1, 1'b1);
      make_image(1, 3, 1'b0, 0, 4);
      send_file(0, 1'b1, 1'b1);
      pixel_fill = FILL_ONES;
      make_image(2, 1, 1'b1, 0, 0);
      send_file(0, 1'b1, 1'b1);
      pixel_fill = FILL_ZERO;
      make_image(2, -1, 1'b0, 0, 0);
      send_file(image_end, 1'b1, 1'b1);
      pixel_fill = FILL_RANDOM;
   endtask

   task automatic test_truncation();
      make_image(2, 2, 1'b0, 0, 0);
      send_file(10, 1'b1, 1'b1);
      send_file(38, 1'b1, 1'b1);
      send_file(56, 1'b1, 1'b1);
      send_file(57, 1'b1, 1'b1);
      send_file(image_end, 1'b1, 1'b1);
      make_image(2, 2, 1'b0, 6, 0);
      send_file(57, 1'b1, 1'b1);
      make_image(1, 1, 1'b1, 0, 0);
      send_file(58, 1'b1, 1'b1);
   endtask

   task automatic test_restart();
      send_byte(8'(BMP_CHAR_B), 1'b1, 1'b1);
      make_image(2, 2, 1'b0, 0, 0);
      send_file(60, 1'b1, 1'b0);
      make_image(3, -2, 1'b1, 2, 0);
      send_file(0, 1'b1, 1'b1);
      repeat (5) send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_extremes();
      make_image(BMPD_MAX_WIDTH, 1, 1'b0, 0, 0);
      send_file(54 + 30, 1'b1, 1'b1);
      make_image(BMPD_MAX_WIDTH, -1, 1'b1, 0, 0);
      send_file(54 + 40, 1'b1, 1'b1);
      make_image(1, BMPD_MAX_HEIGHT, 1'b0, 0, 0);
      send_file(54 + 12, 1'b1, 1'b1);
      make_image(1, -BMPD_MAX_HEIGHT, 1'b1, 0, 0);
      send_file(54 + 16, 1'b1, 1'b1);
   endtask

   task automatic test_backpressure();
      gaps_enabled   = 1'b0;
      stalls_enabled = 1'b0;
      hold_request   = 1'b1;
      make_image(4, 4, 1'b1, 0, 0);
      send_file(0, 1'b1, 1'b1);
      gaps_enabled   = 1'b1;
      stalls_enabled = 1'b1;
   endtask

   task automatic random_file();
      int kind;
      int w;
      int h;
      bit wide;
      kind = $urandom_range(0, 99);
      w    = $urandom_range(1, 5);
      h    = $urandom_range(1, 4);
      if ($urandom_range(0, 1)) h = -h;
      wide = $urandom_range(0, 1);
      pixel_fill = ($urandom_range(0, 15) == 0) ? fill_mode_t'($urandom_range(1, 2))
                                                 : FILL_RANDOM;
      make_image(w, h, wide, $urandom_range(0, 1) ? 0 : $urandom_range(1, 4),
                 $urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
      if (kind < 60) begin
         send_file($urandom_range(0, 1) ? image_end : 0, 1'b1, 1'b1);
      end else if (kind < 78) begin
         send_file($urandom_range(1, image_end), 1'b1, $urandom_range(0, 3) != 0);
      end else if (kind < 92) begin
         case ($urandom_range(0, 7))
            0: begin
               file_image[0] = 8'($urandom);
               file_image[1] = 8'($urandom);
            end
            1: file_image[14] = 8'($urandom_range(0, 39));
            2: file_image[10] = 8'($urandom_range(0, 53));
            3: file_image[26 + $urandom_range(0, 1)] = 8'($urandom);
            4: file_image[28 + $urandom_range(0, 1)] = 8'($urandom);
            5: file_image[30 + $urandom_range(0, 3)] = 8'($urandom_range(1, 255));
            6: file_image[18 + $urandom_range(0, 3)] = 8'($urandom);
            default: file_image[22 + $urandom_range(0, 3)] = 8'($urandom);
         endcase
         send_file(38 + $urandom_range(0, 16), 1'b1, 1'b1);
      end else begin
         repeat ($urandom_range(1, 8))
            send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
      end
      pixel_fill = FILL_RANDOM;
   endtask

   task automatic test_random_files();
      int start;
      start = accepted_bytes;
      while (accepted_bytes - start < RANDOM_BYTES) begin
         gaps_enabled   = ($urandom_range(0, 9) != 0);
         stalls_enabled = gaps_enabled;
         random_file();
      end
      gaps_enabled   = 1'b1;
      stalls_enabled = 1'b1;
   endtask

   initial begin
      clear_decoder_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_signature();
      test_header_checks();
      test_pixel_formats();
      test_truncation();
      test_restart();
      test_extremes();
      test_backpressure();
      test_random_files();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
